/* hw/rtl/bhpq_pkg.sv */
`timescale 1ns / 1ps

package bhpq_pkg;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] in_key;
        logic [15:0] in_tag;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_key;
        logic [15:0] out_tag;
        logic [1:0]  status;
        logic [7:0]  entry_count;
    } t_out_item;

    // One heap slot as held in the entry store
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] tag;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_RM_DESC,
        S_RM_LEFT,
        S_RM_RIGHT,
        S_RM_CMP
    } t_state;

endpackage

/* hw/rtl/bhpq_ram.sv */
`timescale 1ns / 1ps

module bhpq_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/binary_heap_priority_queue.sv */
`timescale 1ns / 1ps
// Clear, unused mode, insert into a full heap and remove from an empty heap strobe o_done in
//   the cycle after accept; insert reads each parent (S_INS_STEP), then compares and moves it
//   down or places the entry (S_INS_CMP); remove reads root and last entry, then per level the
//   children, then compares. The entry store's registered read sets the pace of the sift.
// Throughput: one item at a time; busy falls with the result strobe, taking the next item.
// Reset (synchronous, active low) empties the heap and selects largest-key-first; no stall.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // command channel
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    // result channel
    output logic      o_done,
    output t_out_item o_result,
    // configuration channel: order_select
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    // Slot index and fill count widths; child indices need one more bit than the count
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = CW + 1;

    t_state r_state, n_state;

    logic          r_order, n_order;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_m, n_m;          // current hole position of the sift
    logic [IW-1:0] r_cidx, n_cidx;    // index of the selected child
    t_entry        r_new, n_new;      // entry being inserted
    t_entry        r_last, n_last;    // last entry, sifted down on remove
    t_entry        r_child, n_child;  // selected child during descent
    t_entry        r_root, n_root;    // removed top entry
    logic          r_done, n_done;
    t_out_item     r_res, n_res;

    // Entry store ports
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;

    // Shared rank comparator: true when cmp_a ranks strictly above cmp_b
    logic [31:0]   cmp_a, cmp_b;
    logic          above;

    logic          accept;
    logic          full;
    logic          empty;
    logic [IW-1:0] parent;
    logic [XW-1:0] left_x, right_x, count_x;
    logic          has_left, has_right;

    bhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_res;

    assign full  = (r_count >= CW'(CAPACITY));
    assign empty = (r_count == '0);

    // Tree arithmetic: parent (m-1)/2, children 2m+1 and 2m+2.
    // During remove r_count already holds the count left after removal.
    assign parent    = (r_m - IW'(1)) >> 1;
    assign left_x    = (XW'(r_m) << 1) + XW'(1);
    assign right_x   = (XW'(r_m) << 1) + XW'(2);
    assign count_x   = XW'(r_count);
    assign has_left  = (left_x < count_x);
    assign has_right = (right_x < count_x);

    // Steer the comparator by state
    always_comb begin
        unique case (r_state)
            S_INS_CMP: begin
                cmp_a = r_new.key;
                cmp_b = rd_data.key;
            end
            S_RM_RIGHT: begin
                cmp_a = r_child.key;
                cmp_b = rd_data.key;
            end
            default: begin
                cmp_a = r_child.key;
                cmp_b = r_last.key;
            end
        endcase
        above = r_order ? (cmp_a < cmp_b) : (cmp_a > cmp_b);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.mode == MODE_INSERT && !full) begin
                        n_state = S_INS_STEP;
                    end else if (i_item.mode == MODE_REMOVE && !empty) begin
                        n_state = S_RM_ROOT;
                    end
                end
            end
            S_INS_STEP: n_state = (r_m == '0) ? S_IDLE : S_INS_CMP;
            S_INS_CMP:  n_state = above ? S_INS_STEP : S_IDLE;
            S_RM_ROOT:  n_state = S_RM_LAST;
            S_RM_LAST:  n_state = S_RM_DESC;
            S_RM_DESC:  n_state = has_left ? S_RM_LEFT : S_IDLE;
            S_RM_LEFT:  n_state = has_right ? S_RM_RIGHT : S_RM_CMP;
            S_RM_RIGHT: n_state = S_RM_CMP;
            S_RM_CMP:   n_state = above ? S_RM_DESC : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, store ports and result
    always_comb begin
        n_order = r_order;
        n_count = r_count;
        n_m     = r_m;
        n_cidx  = r_cidx;
        n_new   = r_new;
        n_last  = r_last;
        n_child = r_child;
        n_root  = r_root;
        n_done  = 1'b0;
        n_res   = r_res;
        wr_en   = 1'b0;
        wr_addr = r_m;
        wr_data = r_last;
        rd_addr = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_order = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Default result: nothing removed, status ok, count unchanged
                    n_res.out_key = '0;
                    n_res.out_tag = '0;
                    n_res.status  = STATUS_OK;
                    n_res.entry_count = 8'(r_count);
                    unique case (i_item.mode)
                        MODE_INSERT: begin
                            if (full) begin
                                n_res.status = STATUS_FULL;
                                n_done       = 1'b1;
                            end else begin
                                // Open the hole at the first free slot
                                n_m         = r_count[IW-1:0];
                                n_new.key   = i_item.in_key;
                                n_new.tag   = i_item.in_tag;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        MODE_REMOVE: begin
                            if (empty) begin
                                n_res.status = STATUS_EMPTY;
                                n_done       = 1'b1;
                            end else begin
                                n_count = r_count - CW'(1);
                                rd_addr = '0;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count           = '0;
                            n_res.entry_count = '0;
                            n_done            = 1'b1;
                        end
                        default: begin
                            // Unused mode: leave the heap as is
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_INS_STEP: begin
                if (r_m == '0) begin
                    // Reached the root: drop the new entry here
                    wr_en   = 1'b1;
                    wr_data = r_new;
                    n_done  = 1'b1;
                    n_res.entry_count = 8'(r_count);
                end else begin
                    rd_addr = parent;
                end
            end

            S_INS_CMP: begin
                wr_en = 1'b1;
                if (above) begin
                    // Move the parent down into the hole and climb
                    wr_data = rd_data;
                    n_m     = parent;
                end else begin
                    wr_data = r_new;
                    n_done  = 1'b1;
                    n_res.entry_count = 8'(r_count);
                end
            end

            S_RM_ROOT: begin
                n_root  = rd_data;
                rd_addr = r_count[IW-1:0];
            end

            S_RM_LAST: begin
                n_last = rd_data;
                n_m    = '0;
            end

            S_RM_DESC: begin
                if (has_left) begin
                    rd_addr = left_x[IW-1:0];
                end else begin
                    // Leaf reached: place the last entry in the hole
                    wr_en   = 1'b1;
                    wr_data = r_last;
                    n_done  = 1'b1;
                    n_res.out_key     = r_root.key;
                    n_res.out_tag     = r_root.tag;
                    n_res.entry_count = 8'(r_count);
                end
            end

            S_RM_LEFT: begin
                n_child = rd_data;
                n_cidx  = left_x[IW-1:0];
                if (has_right) begin
                    rd_addr = right_x[IW-1:0];
                end
            end

            S_RM_RIGHT: begin
                // Take the left child only if it ranks strictly above the right
                if (!above) begin
                    n_child = rd_data;
                    n_cidx  = right_x[IW-1:0];
                end
            end

            S_RM_CMP: begin
                wr_en = 1'b1;
                if (above) begin
                    // Promote the child and descend
                    wr_data = r_child;
                    n_m     = r_cidx;
                end else begin
                    wr_data = r_last;
                    n_done  = 1'b1;
                    n_res.out_key     = r_root.key;
                    n_res.out_tag     = r_root.tag;
                    n_res.entry_count = 8'(r_count);
                end
            end

            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_cidx  <= n_cidx;
        r_new   <= n_new;
        r_last  <= n_last;
        r_child <= n_child;
        r_root  <= n_root;
        r_res   <= n_res;
    end

endmodule
